// ----- rtl/code_address_range_lookup_macros.svh -----
`ifndef CODE_ADDRESS_RANGE_LOOKUP_MACROS_SVH
`define CODE_ADDRESS_RANGE_LOOKUP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CARL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("carl assertion failed");
`define CARL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("carl assertion failed");
`else
`define CARL_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define CARL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/carl_pkg.sv -----
package carl_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_NO_MATCH = 3'd2;
    localparam logic [2:0] ST_STORED   = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_FILE_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT = 1'd1;

    localparam logic [5:0] PAGE_SHIFT_RESET = 6'd12;

    typedef struct packed {
        logic latch;
        logic sub_base;
        logic sub_red;
        logic add_fb;
        logic load;
        logic clear;
        logic set_empty;
        logic probe;
        logic compare;
        logic set_no_match;
        logic publish;
    } carl_cmd_t;

    typedef struct packed {
        logic empty;
        logic bounds_done;
        logic hit;
        logic out_free;
    } carl_sts_t;

endpackage

// ----- rtl/carl_ctrl.sv -----
module carl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           op,
    output logic                 in_stall,
    input  carl_pkg::carl_sts_t  sts,
    output carl_pkg::carl_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_CLEAR  = 4'd2;
    localparam logic [3:0] S_CALC1  = 4'd3;
    localparam logic [3:0] S_CALC2  = 4'd4;
    localparam logic [3:0] S_CALC3  = 4'd5;
    localparam logic [3:0] S_PROBE  = 4'd6;
    localparam logic [3:0] S_CMP    = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    case (op)
                        carl_pkg::OP_LOAD:   state_next = S_LOAD;
                        carl_pkg::OP_LOOKUP: state_next = S_CALC1;
                        carl_pkg::OP_CLEAR:  state_next = S_CLEAR;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_FINISH;
            end
            S_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = S_FINISH;
            end
            S_CALC1:
            begin
                cmd.sub_base = 1'b1;
                state_next   = S_CALC2;
            end
            S_CALC2:
            begin
                cmd.sub_red = 1'b1;
                state_next  = S_CALC3;
            end
            S_CALC3:
            begin
                cmd.add_fb = 1'b1;
                if (sts.empty)
                begin
                    cmd.set_empty = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (sts.bounds_done)
                begin
                    cmd.set_no_match = 1'b1;
                    state_next       = S_FINISH;
                end
                else
                begin
                    cmd.probe  = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = sts.hit ? S_FINISH : S_PROBE;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/carl_dp.sv -----
`include "code_address_range_lookup_macros.svh"

module carl_dp #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [carl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [carl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [63:0]                         entry_start,
    input  logic [31:0]                         entry_length,
    input  logic [31:0]                         entry_method,
    input  logic [63:0]                         native_pc,
    input  logic [63:0]                         mapping_base,
    input  logic [63:0]                         mapping_offset,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [2:0]                          status,
    output logic [31:0]                         hit_method,
    output logic [63:0]                         hit_start,
    output logic [31:0]                         hit_length,
    output logic [31:0]                         code_offset,
    input  carl_pkg::carl_cmd_t                 cmd,
    output carl_pkg::carl_sts_t                 sts
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int MEM_W = 128;

    logic [63:0]       file_base_reg;
    logic [5:0]        page_shift_reg;
    logic [CNT_W-1:0]  entry_count_reg;

    logic [MEM_W-1:0]  table_mem [TABLE_DEPTH];
    logic [MEM_W-1:0]  rdata_reg;

    logic [63:0]       ld_start_reg;
    logic [31:0]       ld_length_reg;
    logic [31:0]       ld_method_reg;
    logic [63:0]       acc_reg;
    logic [63:0]       base_reg;
    logic [63:0]       red_reg;

    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  hi_reg;
    logic [IDX_W-1:0]  mid_reg;
    logic [CNT_W:0]    mid_sum;
    logic [IDX_W-1:0]  mid;

    logic [2:0]        res_status_reg;
    logic [31:0]       res_method_reg;
    logic [63:0]       res_start_reg;
    logic [31:0]       res_length_reg;
    logic [31:0]       res_offset_reg;

    logic              out_valid_reg;
    logic [63:0]       page_mask;
    logic [63:0]       rd_start;
    logic [31:0]       rd_length;
    logic [31:0]       rd_method;
    logic              below;
    logic              above;
    logic              hit;
    logic [63:0]       diff;
    logic              full;

    assign page_mask = (64'd1 << page_shift_reg) - 64'd1;
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg} - {{CNT_W{1'b0}}, 1'b1};
    assign mid       = mid_sum[IDX_W:1];

    assign rd_start  = rdata_reg[127:64];
    assign rd_length = rdata_reg[63:32];
    assign rd_method = rdata_reg[31:0];
    assign below     = acc_reg < rd_start;
    assign diff      = acc_reg - rd_start;
    assign above     = !below && (diff >= {32'd0, rd_length});
    assign hit       = !below && !above;
    assign full      = (entry_count_reg == CNT_W'(TABLE_DEPTH));

    assign sts.empty       = (entry_count_reg == '0);
    assign sts.bounds_done = (lo_reg >= hi_reg);
    assign sts.hit         = hit;
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_base_reg  <= '0;
            page_shift_reg <= carl_pkg::PAGE_SHIFT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                carl_pkg::REG_FILE_BASE:  file_base_reg  <= cfg_data;
                carl_pkg::REG_PAGE_SHIFT: page_shift_reg <= cfg_data[5:0];
                default:                  file_base_reg  <= file_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cmd.clear)
        begin
            entry_count_reg <= '0;
        end
        else if (cmd.load && !full)
        begin
            entry_count_reg <= entry_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            table_mem[entry_count_reg[IDX_W-1:0]] <= {ld_start_reg, ld_length_reg, ld_method_reg};
        end
        if (cmd.probe)
        begin
            rdata_reg <= table_mem[mid];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            ld_start_reg  <= entry_start;
            ld_length_reg <= entry_length;
            ld_method_reg <= entry_method;
            acc_reg       <= native_pc;
            base_reg      <= mapping_base;
            red_reg       <= mapping_offset & page_mask;
        end
        else if (cmd.sub_base)
        begin
            acc_reg <= acc_reg - base_reg;
        end
        else if (cmd.sub_red)
        begin
            acc_reg <= acc_reg - red_reg;
        end
        else if (cmd.add_fb)
        begin
            acc_reg <= acc_reg + file_base_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg  <= '0;
            hi_reg  <= '0;
            mid_reg <= '0;
        end
        else if (cmd.add_fb)
        begin
            lo_reg <= '0;
            hi_reg <= entry_count_reg;
        end
        else if (cmd.probe)
        begin
            mid_reg <= mid;
        end
        else if (cmd.compare && !hit)
        begin
            if (above)
            begin
                lo_reg <= CNT_W'(mid_reg) + 1'b1;
            end
            else
            begin
                hi_reg <= CNT_W'(mid_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load || cmd.clear || cmd.set_empty || cmd.set_no_match)
        begin
            res_method_reg <= '0;
            res_start_reg  <= '0;
            res_length_reg <= '0;
            res_offset_reg <= '0;
        end
        if (cmd.load)
        begin
            res_status_reg <= full ? carl_pkg::ST_FULL : carl_pkg::ST_STORED;
        end
        else if (cmd.clear)
        begin
            res_status_reg <= carl_pkg::ST_CLEARED;
        end
        else if (cmd.set_empty)
        begin
            res_status_reg <= carl_pkg::ST_EMPTY;
        end
        else if (cmd.set_no_match)
        begin
            res_status_reg <= carl_pkg::ST_NO_MATCH;
        end
        else if (cmd.compare && hit)
        begin
            res_status_reg <= carl_pkg::ST_HIT;
            res_method_reg <= rd_method;
            res_start_reg  <= rd_start;
            res_length_reg <= rd_length;
            res_offset_reg <= diff[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            status      <= res_status_reg;
            hit_method  <= res_method_reg;
            hit_start   <= res_start_reg;
            hit_length  <= res_length_reg;
            code_offset <= res_offset_reg;
        end
    end

    `CARL_ASSERT_SAME(a_publish_free, clk, rst_n, cmd.publish, !out_valid_reg || !out_stall)
    `CARL_ASSERT_NEXT(a_load_count, clk, rst_n, cmd.load && !full, entry_count_reg == $past(entry_count_reg) + 1'b1)
    `CARL_ASSERT_SAME(a_probe_range, clk, rst_n, cmd.probe, CNT_W'(mid) < entry_count_reg)
    `CARL_ASSERT_NEXT(a_bounds_shrink, clk, rst_n, cmd.compare && !hit, (hi_reg - lo_reg) < $past(hi_reg - lo_reg))

endmodule

// ----- rtl/code_address_range_lookup.sv -----
// Load and clear go through their own state and then the finish state, which publishes
// the result once the output is free. A lookup subtracts mapping_base, then mapping_offset
// masked to page_shift bits, adds file_base, ends on an empty table, else alternates probe
// and compare, at most floor(log2(entries)) + 1 probes, until a hit or the bounds meet.
// in_stall is high until the result is published; an output stall holds result and input.
// Reset clears control, entry count, file_base to 0, page_shift to 12; table data undefined.
module code_address_range_lookup #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [carl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [carl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       op,
    input  logic [63:0]                      entry_start,
    input  logic [31:0]                      entry_length,
    input  logic [31:0]                      entry_method,
    input  logic [63:0]                      native_pc,
    input  logic [63:0]                      mapping_base,
    input  logic [63:0]                      mapping_offset,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       status,
    output logic [31:0]                      hit_method,
    output logic [63:0]                      hit_start,
    output logic [31:0]                      hit_length,
    output logic [31:0]                      code_offset
);

    carl_pkg::carl_cmd_t cmd;
    carl_pkg::carl_sts_t sts;

    carl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    carl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .entry_start    (entry_start),
        .entry_length   (entry_length),
        .entry_method   (entry_method),
        .native_pc      (native_pc),
        .mapping_base   (mapping_base),
        .mapping_offset (mapping_offset),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .status         (status),
        .hit_method     (hit_method),
        .hit_start      (hit_start),
        .hit_length     (hit_length),
        .code_offset    (code_offset),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule
